@@ rtl/core/stc_pkg.sv @@
// Shared types and constants for the 3x3 stencil smoothing block.
// Register map, reset values and the configuration struct.
// No dependencies; the files that use it refer to it by scoped names.
package stc_pkg;

  // Fixed field widths of the configuration registers, position outputs and APB-style port.
  localparam int unsigned COEF_W     = 16;
  localparam int unsigned SIZE_W     = 10;
  localparam int unsigned POS_W      = 10;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 4;

  // Fraction width of the Q0.16 coefficients and of their products.
  localparam int unsigned FRAC_W     = 16;

  // Register indexes, one word apart.
  typedef enum logic [1:0] {
    REG_CORNER = 2'd0,
    REG_EDGE   = 2'd1,
    REG_CENTER = 2'd2,
    REG_SIZE   = 2'd3
  } reg_idx_e;

  // Reset values of the registers.
  localparam logic [COEF_W-1:0] CORNER_RST = 16'd3277;
  localparam logic [COEF_W-1:0] EDGE_RST   = 16'd6554;
  localparam logic [COEF_W-1:0] CENTER_RST = 16'd26214;
  localparam logic [SIZE_W-1:0] SIZE_RST   = 10'd1022;

  // Current configuration as seen by the datapath.
  typedef struct packed {
    logic [COEF_W-1:0] corner_coef;
    logic [COEF_W-1:0] edge_coef;
    logic [COEF_W-1:0] center_coef;
    logic [SIZE_W-1:0] interior_size;
  } cfg_t;

endpackage

@@ rtl/core/stc_stream_if.sv @@
// Valid/ready stream interfaces for the pixel input and the filtered output.
// Depends on stc_pkg for the position field width.
interface stc_pix_if #(
  parameter int unsigned PIXEL_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel;
  logic                  frame_start;

  modport source (output valid, pixel, frame_start, input ready);
  modport sink   (input valid, pixel, frame_start, output ready);
endinterface

interface stc_res_if #(
  parameter int unsigned PIXEL_BITS = 16
);
  logic                       valid;
  logic                       ready;
  logic [PIXEL_BITS-1:0]      smoothed;
  logic [stc_pkg::POS_W-1:0]  out_row;
  logic [stc_pkg::POS_W-1:0]  out_col;
  logic                       last_of_frame;

  modport source (output valid, smoothed, out_row, out_col, last_of_frame, input ready);
  modport sink   (input valid, smoothed, out_row, out_col, last_of_frame, output ready);
endinterface

@@ rtl/core/stc_cfg_regs.sv @@
// APB-style configuration registers of the stencil smoothing block.
// Depends on stc_pkg for the register map and the configuration struct.
module stc_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [stc_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [stc_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [stc_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  output stc_pkg::cfg_t                     cfg_o
);

  stc_pkg::cfg_t     cfg_q;
  stc_pkg::reg_idx_e reg_idx;
  logic              wr_en;

  assign reg_idx = stc_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  // Register writes complete in the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.corner_coef   <= stc_pkg::CORNER_RST;
      cfg_q.edge_coef     <= stc_pkg::EDGE_RST;
      cfg_q.center_coef   <= stc_pkg::CENTER_RST;
      cfg_q.interior_size <= stc_pkg::SIZE_RST;
    end else if (wr_en) begin
      case (reg_idx)
        stc_pkg::REG_CORNER: cfg_q.corner_coef   <= pwdata[stc_pkg::COEF_W-1:0];
        stc_pkg::REG_EDGE:   cfg_q.edge_coef     <= pwdata[stc_pkg::COEF_W-1:0];
        stc_pkg::REG_CENTER: cfg_q.center_coef   <= pwdata[stc_pkg::COEF_W-1:0];
        stc_pkg::REG_SIZE:   cfg_q.interior_size <= pwdata[stc_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back of the addressed register.
  always_comb begin
    case (reg_idx)
      stc_pkg::REG_CORNER: prdata = stc_pkg::APB_DATA_W'(cfg_q.corner_coef);
      stc_pkg::REG_EDGE:   prdata = stc_pkg::APB_DATA_W'(cfg_q.edge_coef);
      stc_pkg::REG_CENTER: prdata = stc_pkg::APB_DATA_W'(cfg_q.center_coef);
      stc_pkg::REG_SIZE:   prdata = stc_pkg::APB_DATA_W'(cfg_q.interior_size);
      default:             prdata = '0;
    endcase
  end

endmodule

@@ rtl/core/stc_linebuf.sv @@
// Two line buffers held side by side in one memory word.
// Registered read with bypass of a write to the same column in the same cycle.
// No package dependencies.
module stc_linebuf #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned DW    = 32
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [DW-1:0]            wr_data_i,
  output logic [DW-1:0]            rd_data_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rd_q;
  logic [DW-1:0] byp_data_q;
  logic          byp_q;

  // Memory port: one write and one read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  // A read that collides with the write of the same cycle takes the new data.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      byp_q      <= wr_en_i && (wr_addr_i == rd_addr_i);
      byp_data_q <= wr_data_i;
    end
  end

  assign rd_data_o = byp_q ? byp_data_q : rd_q;

endmodule

@@ rtl/core/stc_window.sv @@
// 3x3 window registers, neighbour sums and the three coefficient products.
// Depends on stc_pkg for the configuration struct.
module stc_window #(
  parameter int unsigned PB = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 shift_i,
  input  logic [PB-1:0]        top_i,
  input  logic [PB-1:0]        mid_i,
  input  logic [PB-1:0]        pix_i,
  input  stc_pkg::cfg_t        cfg_i,
  output logic [PB+17:0]       prod_diag_o,
  output logic [PB+17:0]       prod_side_o,
  output logic [PB+17:0]       prod_ctr_o
);

  localparam int unsigned SUM_W  = PB + 2;
  localparam int unsigned PROD_W = SUM_W + stc_pkg::COEF_W;

  // Slots 0..2 hold the column two back (top, middle, bottom), 3..5 the previous one.
  logic [PB-1:0]     win_q [6];
  logic [SUM_W-1:0]  diag_sum;
  logic [SUM_W-1:0]  side_sum;
  logic [PROD_W-1:0] prod_diag_q;
  logic [PROD_W-1:0] prod_side_q;
  logic [PROD_W-1:0] prod_ctr_q;

  // Slide the window by one column as each pixel leaves the input stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (shift_i) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= top_i;
      win_q[4] <= mid_i;
      win_q[5] <= pix_i;
    end
  end

  // Diagonal and side neighbour sums of the completed window.
  assign diag_sum = SUM_W'(win_q[0]) + SUM_W'(win_q[2]) + SUM_W'(top_i) + SUM_W'(pix_i);
  assign side_sum = SUM_W'(win_q[1]) + SUM_W'(win_q[3]) + SUM_W'(win_q[5]) + SUM_W'(mid_i);

  // One multiplier per term, registered.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      prod_diag_q <= PROD_W'(diag_sum) * PROD_W'(cfg_i.corner_coef);
      prod_side_q <= PROD_W'(side_sum) * PROD_W'(cfg_i.edge_coef);
      prod_ctr_q  <= PROD_W'(win_q[4]) * PROD_W'(cfg_i.center_coef);
    end
  end

  assign prod_diag_o = prod_diag_q;
  assign prod_side_o = prod_side_q;
  assign prod_ctr_o  = prod_ctr_q;

endmodule

@@ rtl/core/stc_round.sv @@
// Final sum of the three products, round to nearest and saturate to the pixel range.
// Depends on stc_pkg for the fraction width of the coefficients.
module stc_round #(
  parameter int unsigned PB = 16
) (
  input  logic [PB+17:0] prod_diag_i,
  input  logic [PB+17:0] prod_side_i,
  input  logic [PB+17:0] prod_ctr_i,
  output logic [PB-1:0]  smoothed_o
);

  localparam int unsigned PROD_W = PB + 18;
  localparam int unsigned ACC_W  = PROD_W + 2;
  localparam int unsigned RES_W  = ACC_W - stc_pkg::FRAC_W;
  localparam logic [ACC_W-1:0] HALF_LSB = ACC_W'(1) << (stc_pkg::FRAC_W - 1);

  logic [ACC_W-1:0] acc;
  logic [RES_W-1:0] res;

  // Ties round up; anything above the pixel range clips to full scale.
  assign acc = ACC_W'(prod_diag_i) + ACC_W'(prod_side_i) + ACC_W'(prod_ctr_i) + HALF_LSB;
  assign res = acc[ACC_W-1:stc_pkg::FRAC_W];
  assign smoothed_o = (|res[RES_W-1:PB]) ? {PB{1'b1}} : res[PB-1:0];

endmodule

@@ rtl/core/stencil_smoothing_3x3.sv @@
// Streaming 3x3 smoothing filter: top level.
// Pixels of a square grid, border included, arrive in raster order on pix_i,
// one transfer per pixel; frame_start on a transfer places it at row 0, column 0.
// Every interior pixel yields one transfer on res_o with the weighted sum of its
// 3x3 neighbourhood, rounded and saturated, plus its interior row and column;
// last_of_frame marks the bottom-right interior pixel. Border pixels yield nothing.
// The user must write the coefficients and the interior size over the APB-style port
// only while the stream is idle; the block itself does no check on this. pready is
// always high and reads return the register value. Throughput: one pixel per clock
// while res_o keeps taking results. The line buffers sit in a single memory with one
// read and one write per cycle; the read for a pixel is issued as it is accepted.
// The pipeline has three register stages (input with line-buffer data, products,
// result). When res_o is stalled, pixels are still taken until a result waits in
// each of the result and product stages and a pixel waits in the input stage;
// border pixels leave no result, so several of them may pass before pix_i.ready drops.
// Reset clears the counters, the window and all valid flags; the line buffers are
// not cleared, since every interior result reads only rows of its own grid.
// Depends on stc_pkg, the stream interfaces and the stc_* submodules.
module stencil_smoothing_3x3 #(
  parameter int unsigned MAX_GRID_SIDE = 1024,
  parameter int unsigned PIXEL_BITS    = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  stc_pix_if.sink                        pix_i,
  stc_res_if.source                      res_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [stc_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [stc_pkg::APB_DATA_W-1:0] pwdata,
  output logic [stc_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);

  localparam int unsigned PB    = PIXEL_BITS;
  localparam int unsigned CW    = $clog2(MAX_GRID_SIDE);
  localparam int unsigned NW    = ((CW + 1) > stc_pkg::SIZE_W) ? (CW + 1) : stc_pkg::SIZE_W;
  localparam int unsigned SW    = NW + 1;
  localparam int unsigned POS_W = stc_pkg::POS_W;

  stc_pkg::cfg_t cfg;

  // Configuration registers.
  stc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Grid side from the interior size (zero counts as one), clamped to what the line buffers hold.
  logic [SW-1:0] size_ext;
  logic [SW-1:0] size_lim;
  logic [SW-1:0] side;

  assign size_ext = (cfg.interior_size == '0) ? SW'(1) : SW'(cfg.interior_size);
  assign size_lim = SW'(MAX_GRID_SIDE - 2);
  assign side     = ((size_ext > size_lim) ? size_lim : size_ext) + SW'(2);

  // Pipeline handshake: each stage advances when it is empty or the next one moves.
  logic a_valid_q, b_valid_q, o_valid_q;
  logic a_ready, b_ready, o_ready;
  logic in_fire;
  logic a_go;

  assign o_ready     = !o_valid_q || res_o.ready;
  assign b_ready     = !b_valid_q || o_ready;
  assign a_ready     = !a_valid_q || b_ready;
  assign pix_i.ready = a_ready;
  assign in_fire     = pix_i.valid && a_ready;
  assign a_go        = a_valid_q && b_ready;

  // Position of the pixel being accepted and of the one after it.
  logic [CW-1:0] row_q, col_q;
  logic [CW-1:0] row_d, col_d;
  logic [CW-1:0] r_cur, c_cur;
  logic [SW-1:0] r_ext, c_ext;
  logic [SW-1:0] r_inc, c_inc;
  logic          emit_cur;
  logic          last_cur;

  assign r_cur = pix_i.frame_start ? '0 : row_q;
  assign c_cur = pix_i.frame_start ? '0 : col_q;
  assign r_ext = SW'(r_cur);
  assign c_ext = SW'(c_cur);
  assign r_inc = r_ext + SW'(1);
  assign c_inc = c_ext + SW'(1);

  always_comb begin
    row_d = r_cur;
    col_d = c_inc[CW-1:0];
    if (c_inc >= side) begin
      col_d = '0;
      row_d = (r_inc >= side) ? '0 : r_inc[CW-1:0];
    end
  end

  assign emit_cur = (r_ext >= SW'(2)) && (c_ext >= SW'(2)) && (r_ext < side) && (c_ext < side);
  assign last_cur = (r_ext == side - SW'(1)) && (c_ext == side - SW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (in_fire) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // Input stage: the accepted pixel and its position tags.
  logic             a_emit_q, a_last_q;
  logic [POS_W-1:0] a_row_q, a_col_q;
  logic [CW-1:0]    a_addr_q;
  logic [PB-1:0]    a_pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      a_emit_q  <= 1'b0;
    end else if (a_ready) begin
      a_valid_q <= pix_i.valid;
      a_emit_q  <= pix_i.valid && emit_cur;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_last_q <= last_cur;
      a_row_q  <= POS_W'(r_ext - SW'(1));
      a_col_q  <= POS_W'(c_ext - SW'(1));
      a_addr_q <= c_cur;
      a_pix_q  <= pix_i.pixel;
    end
  end

  // Line buffers: read the column on acceptance, write it back as the pixel moves on.
  logic [2*PB-1:0] lb_rd;
  logic [PB-1:0]   lb_top, lb_mid;

  stc_linebuf #(
    .DEPTH (MAX_GRID_SIDE),
    .DW    (2 * PB)
  ) u_linebuf (
    .clk_i     (clk_i),
    .rd_en_i   (in_fire),
    .rd_addr_i (c_cur),
    .wr_en_i   (a_go),
    .wr_addr_i (a_addr_q),
    .wr_data_i ({lb_mid, a_pix_q}),
    .rd_data_o (lb_rd)
  );

  assign lb_top = lb_rd[2*PB-1:PB];
  assign lb_mid = lb_rd[PB-1:0];

  // Window and products; the product registers form the second stage.
  logic [PB+17:0] prod_diag, prod_side, prod_ctr;

  stc_window #(
    .PB (PB)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .shift_i     (a_go),
    .top_i       (lb_top),
    .mid_i       (lb_mid),
    .pix_i       (a_pix_q),
    .cfg_i       (cfg),
    .prod_diag_o (prod_diag),
    .prod_side_o (prod_side),
    .prod_ctr_o  (prod_ctr)
  );

  logic             b_last_q;
  logic [POS_W-1:0] b_row_q, b_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_ready) begin
      b_valid_q <= a_valid_q && a_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_go) begin
      b_last_q <= a_last_q;
      b_row_q  <= a_row_q;
      b_col_q  <= a_col_q;
    end
  end

  // Result stage: rounded, saturated value in the output register.
  logic [PB-1:0]    smoothed;
  logic [PB-1:0]    o_smoothed_q;
  logic             o_last_q;
  logic [POS_W-1:0] o_row_q, o_col_q;

  stc_round #(
    .PB (PB)
  ) u_round (
    .prod_diag_i (prod_diag),
    .prod_side_i (prod_side),
    .prod_ctr_i  (prod_ctr),
    .smoothed_o  (smoothed)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (o_ready) begin
      o_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_ready && b_valid_q) begin
      o_smoothed_q <= smoothed;
      o_last_q     <= b_last_q;
      o_row_q      <= b_row_q;
      o_col_q      <= b_col_q;
    end
  end

  assign res_o.valid         = o_valid_q;
  assign res_o.smoothed      = o_smoothed_q;
  assign res_o.out_row       = o_row_q;
  assign res_o.out_col       = o_col_q;
  assign res_o.last_of_frame = o_last_q;

`ifndef SYNTH
  // A frame start puts the pixel at the origin, so the next one is at column 1.
  a_frame_start_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && pix_i.frame_start |=> (col_q == CW'(1)) && (row_q == '0))
    else $error("position counters not resynchronized by frame start");

  // An interior pixel leaving the input stage always lands in the product stage.
  a_emit_to_b: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q && a_emit_q && b_ready |=> b_valid_q)
    else $error("interior pixel dropped between input and product stage");

  // Interior positions are never on the first row or column.
  a_interior_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q && a_emit_q |-> (a_row_q != '0) && (a_col_q != '0))
    else $error("result tagged with a border position");

  // The last result of a grid sits on the diagonal of the square interior.
  a_last_diag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_valid_q && o_last_q |-> o_row_q == o_col_q)
    else $error("last_of_frame away from the bottom-right corner");
`endif

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the 3x3 stencil smoothing block.
// Streams square grids through the pixel interface, predicts every filtered pixel,
// and checks each result transfer in order. Needs stc_pkg, the stream interfaces and the RTL.
module testbench;

  localparam int unsigned PIX_W       = 16;
  localparam int unsigned MAX_SIDE    = 1024;
  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned SHOW_LIMIT  = 100;
  localparam int unsigned ITEM_BUDGET = 1250;
  localparam int unsigned HOLD_AT     = 150;
  localparam int unsigned POS_W       = stc_pkg::POS_W;
  localparam int unsigned COEF_W      = stc_pkg::COEF_W;
  localparam int unsigned SIZE_W      = stc_pkg::SIZE_W;
  localparam int unsigned FRAC_W      = stc_pkg::FRAC_W;
  localparam int unsigned APB_ADDR_W  = stc_pkg::APB_ADDR_W;
  localparam int unsigned APB_DATA_W  = stc_pkg::APB_DATA_W;

  // One pixel to send and one filtered pixel to compare.
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } pix_item_t;

  // exact is low when the value depends on a line buffer entry never written.
  typedef struct packed {
    logic [PIX_W-1:0] smoothed;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             eof;
    logic             exact;
  } smooth_t;

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  stc_pix_if #(.PIXEL_BITS(PIX_W)) pix ();
  stc_res_if #(.PIXEL_BITS(PIX_W)) res ();

  stencil_smoothing_3x3 #(
    .MAX_GRID_SIDE(MAX_SIDE),
    .PIXEL_BITS   (PIX_W)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix),
    .res_o  (res),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Pixels waiting to be sent and filtered pixels waiting to arrive.
  pix_item_t pixel_q[$];
  smooth_t   smooth_q[$];

  // Shadow of the configuration registers.
  stc_pkg::cfg_t cfg_now;

  // Predictor state: two line buffers, the 3x3 window and the scan position.
  bit [PIX_W-1:0] line_top[0:MAX_SIDE-1];
  bit [PIX_W-1:0] line_mid[0:MAX_SIDE-1];
  bit [PIX_W-1:0] win[0:5];
  int unsigned    at_row = 0;
  int unsigned    at_col = 0;

  // Which line buffer entries hold written data; the window is cleared by reset.
  bit top_known[0:MAX_SIDE-1];
  bit mid_known[0:MAX_SIDE-1];
  bit win_known[0:5] = '{default: 1'b1};

  int unsigned errors       = 0;
  int unsigned shown        = 0;
  int unsigned n_results    = 0;
  int unsigned sent_items   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_left    = 0;
  bit          held_once    = 0;
  bit          steady       = 0;

  // Clock with a period of 10.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Grid side for a given size register, with out-of-range sizes clamped.
  function automatic int unsigned side_of(input logic [SIZE_W-1:0] sz);
    int unsigned n;
    n = 32'(sz);
    if (n < 1) n = 1;
    if (n > MAX_SIDE - 2) n = MAX_SIDE - 2;
    return n + 2;
  endfunction

  // Text of one filtered pixel for the mismatch report.
  function automatic string fmt_res(input smooth_t s);
    return $sformatf("smoothed=%0d row=%0d col=%0d last=%0b", s.smoothed, s.row, s.col, s.eof);
  endfunction

  // Advance the filter model by one pixel and queue the filtered pixel it yields, if any.
  function automatic void predict_smooth(input bit [PIX_W-1:0] px, input bit fs);
    int unsigned side, r, c;
    bit [PIX_W-1:0] top, mid;
    bit [63:0] diag, sides, acc, rnd;
    bit exact;
    smooth_t want;
    side = side_of(cfg_now.interior_size);
    if (fs) begin
      at_row = 0;
      at_col = 0;
    end
    r = at_row;
    c = at_col;
    if (c >= MAX_SIDE) c = 0;
    top = line_top[c];
    mid = line_mid[c];

    // A pixel that closes a window centered on an interior position yields a result.
    if (r >= 2 && c >= 2 && r < side && c < side) begin
      exact = top_known[c] && mid_known[c];
      for (int i = 0; i < 6; i++) exact = exact && win_known[i];
      diag  = 64'(win[0]) + 64'(win[2]) + 64'(top) + 64'(px);
      sides = 64'(win[1]) + 64'(win[3]) + 64'(win[5]) + 64'(mid);
      acc   = diag * 64'(cfg_now.corner_coef) + sides * 64'(cfg_now.edge_coef)
            + 64'(win[4]) * 64'(cfg_now.center_coef);
      rnd   = (acc + 64'd32768) >> FRAC_W;
      want.smoothed = (rnd > 64'hFFFF) ? 16'hFFFF : rnd[PIX_W-1:0];
      want.row      = POS_W'(r - 1);
      want.col      = POS_W'(c - 1);
      want.eof      = (r == side - 1) && (c == side - 1);
      want.exact    = exact;
      smooth_q.push_back(want);
    end

    // Slide the window one column and update the line buffers.
    win[0] = win[3];
    win[1] = win[4];
    win[2] = win[5];
    win[3] = top;
    win[4] = mid;
    win[5] = px;
    win_known[0] = win_known[3];
    win_known[1] = win_known[4];
    win_known[2] = win_known[5];
    win_known[3] = top_known[c];
    win_known[4] = mid_known[c];
    win_known[5] = 1'b1;
    line_top[c]  = mid;
    line_mid[c]  = px;
    top_known[c] = mid_known[c];
    mid_known[c] = 1'b1;

    c = c + 1;
    if (c >= side) begin
      c = 0;
      r = r + 1;
      if (r >= side) r = 0;
    end
    at_row = r;
    at_col = c;
  endfunction

  // Pixel values: 0 full range, 1 extremes only, 2 near full scale, 3 dark, else mixed.
  function automatic logic [PIX_W-1:0] pick_pixel(input int unsigned mode);
    int unsigned m;
    m = (mode > 3) ? $urandom_range(0, 3) : mode;
    case (m)
      0: return PIX_W'($urandom_range(0, 65535));
      1: return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
      2: return PIX_W'($urandom_range(60000, 65535));
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_pixel(input logic [PIX_W-1:0] p, input bit fs);
    pix_item_t it;
    it.pixel       = p;
    it.frame_start = fs;
    pixel_q.push_back(it);
    sent_items++;
  endtask

  task automatic push_grid(input int unsigned len, input bit fs_first, input int unsigned mode);
    for (int unsigned i = 0; i < len; i++) push_pixel(pick_pixel(mode), fs_first && i == 0);
  endtask

  // Register write over the APB-style port: setup cycle, then access cycle.
  task automatic reg_write(input stc_pkg::reg_idx_e idx, input logic [APB_DATA_W-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      stc_pkg::REG_CORNER: cfg_now.corner_coef   = val[COEF_W-1:0];
      stc_pkg::REG_EDGE:   cfg_now.edge_coef     = val[COEF_W-1:0];
      stc_pkg::REG_CENTER: cfg_now.center_coef   = val[COEF_W-1:0];
      stc_pkg::REG_SIZE:   cfg_now.interior_size = val[SIZE_W-1:0];
      default: ;
    endcase
  endtask

  // Wait until every pixel is sent and every filtered pixel has come back, plus latency.
  task automatic drain_stream();
    do @(negedge clk_i);
    while (pixel_q.size() != 0 || pix.valid || smooth_q.size() != 0);
    repeat (6) @(negedge clk_i);
  endtask

  // New coefficients and size; coefficient sets range from mild to saturating.
  task automatic pick_config();
    int unsigned cmode, smode;
    logic [COEF_W-1:0] cf[3];
    logic [SIZE_W-1:0] sz;
    cmode = $urandom_range(0, 3);
    for (int i = 0; i < 3; i++) begin
      case (cmode)
        0: cf[i] = COEF_W'($urandom_range(0, 65535));
        1: cf[i] = COEF_W'($urandom_range(0, 7000));
        2: cf[i] = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
        default: cf[i] = COEF_W'($urandom_range(0, (i == 2) ? 40000 : 8000));
      endcase
    end
    smode = $urandom_range(0, 99);
    if (smode < 70) sz = SIZE_W'($urandom_range(1, 6));
    else if (smode < 88) sz = SIZE_W'($urandom_range(7, 24));
    else if (smode < 93) sz = '0;
    else if (smode < 96) sz = 10'd1023;
    else sz = SIZE_W'($urandom_range(100, 1022));
    reg_write(stc_pkg::REG_CORNER, APB_DATA_W'(cf[0]));
    reg_write(stc_pkg::REG_EDGE, APB_DATA_W'(cf[1]));
    reg_write(stc_pkg::REG_CENTER, APB_DATA_W'(cf[2]));
    reg_write(stc_pkg::REG_SIZE, APB_DATA_W'(sz));
  endtask

  // Mostly whole grids with random content; some aborted by a new frame start, some noise.
  task automatic fill_phase(input int unsigned budget);
    int unsigned added, side, full, len, act, mode, k;
    added = 0;
    while (added < budget) begin
      side = side_of(cfg_now.interior_size);
      full = side * side;
      if (full > 700) begin
        len = (side > 200) ? $urandom_range(50, 400) : $urandom_range(2 * side, 4 * side);
      end else begin
        len = full;
      end
      act  = $urandom_range(0, 99);
      mode = $urandom_range(0, 4);
      if (act < 55) begin
        push_grid(len, 1'b1, mode);
      end else if (act < 72) begin
        push_grid(len, 1'b0, mode);
      end else if (act < 87) begin
        len = $urandom_range(1, len - 1);
        push_grid(len, 1'b1, mode);
      end else begin
        len = $urandom_range(1, 6);
        for (k = 0; k < len; k++) push_pixel(pick_pixel(0), $urandom_range(0, 3) == 0);
      end
      added += len;
    end
  endtask

  // Pixel driver: offers the next queued pixel, idling at random.
  always @(posedge clk_i or negedge rst_ni) begin : feed_proc
    pix_item_t nxt;
    if (!rst_ni) begin
      pix.valid       <= 1'b0;
      pix.pixel       <= '0;
      pix.frame_start <= 1'b0;
    end else if (!pix.valid || pix.ready) begin
      if (pixel_q.size() != 0 && (steady || $urandom_range(0, 99) >= 17)) begin
        nxt = pixel_q.pop_front();
        pix.valid       <= 1'b1;
        pix.pixel       <= nxt.pixel;
        pix.frame_start <= nxt.frame_start;
      end else begin
        pix.valid <= 1'b0;
      end
    end
  end

  // Monitor: predicts on each pixel transfer, checks each result transfer, drives ready.
  always @(posedge clk_i or negedge rst_ni) begin : watch_proc
    smooth_t got, want;
    if (!rst_ni) begin
      res.ready <= 1'b0;
    end else begin
      if (pix.valid && pix.ready) predict_smooth(pix.pixel, pix.frame_start);

      if (res.valid && res.ready) begin
        n_results++;
        got.smoothed = res.smoothed;
        got.row      = res.out_row;
        got.col      = res.out_col;
        got.eof      = res.last_of_frame;
        got.exact    = 1'b1;
        if (smooth_q.size() == 0) begin
          errors++;
          if (shown < SHOW_LIMIT)
            $display("%0t: unexpected result, expected none, got %s", $time, fmt_res(got));
          shown++;
        end else begin
          want = smooth_q.pop_front();
          if ((want.exact && got.smoothed !== want.smoothed) || got.row !== want.row ||
              got.col !== want.col || got.eof !== want.eof) begin
            errors++;
            if (shown < SHOW_LIMIT)
              $display("%0t: mismatch, expected %s, got %s",
                       $time, fmt_res(want), fmt_res(got));
            shown++;
          end
        end
      end

      // One long hold-off once results are flowing, then short ones now and then.
      if (!held_once && res.valid && n_results >= HOLD_AT) begin
        held_once = 1'b1;
        hold_left = 300;
      end else if (hold_left == 0 && $urandom_range(0, 2999) == 0) begin
        hold_left = $urandom_range(30, 200);
      end
      if (hold_left != 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= steady || $urandom_range(0, 99) >= 17;
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (pix.valid && pix.ready) || (res.valid && res.ready) || psel) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("stencil_smoothing_3x3 test failed");
        $finish;
      end
    end
  end

  // Test sequence.
  initial begin
    rst_ni  = 1'b0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    cfg_now.corner_coef   = stc_pkg::CORNER_RST;
    cfg_now.edge_coef     = stc_pkg::EDGE_RST;
    cfg_now.center_coef   = stc_pkg::CENTER_RST;
    cfg_now.interior_size = stc_pkg::SIZE_RST;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset coefficients on back-to-back small grids, without idling; the long
    // receiver hold-off falls inside this stretch.
    reg_write(stc_pkg::REG_SIZE, APB_DATA_W'(6));
    @(negedge clk_i);
    steady = 1'b1;
    for (int g = 0; g < 6; g++) push_grid(64, (g % 2) == 0, 4);
    drain_stream();
    steady = 1'b0;

    // Size zero acts as one; full-scale weights and pixels saturate.
    reg_write(stc_pkg::REG_CORNER, APB_DATA_W'(16'hFFFF));
    reg_write(stc_pkg::REG_EDGE, APB_DATA_W'(16'hFFFF));
    reg_write(stc_pkg::REG_CENTER, APB_DATA_W'(16'hFFFF));
    reg_write(stc_pkg::REG_SIZE, '0);
    @(negedge clk_i);
    push_pixel(16'hFFFF, 1'b1);
    for (int i = 1; i < 9; i++) push_pixel(16'hFFFF, 1'b0);
    drain_stream();

    // Exact half on the rounding boundary rounds up; grid follows the wrap without a frame start.
    reg_write(stc_pkg::REG_CORNER, '0);
    reg_write(stc_pkg::REG_EDGE, '0);
    reg_write(stc_pkg::REG_CENTER, APB_DATA_W'(16'd32768));
    reg_write(stc_pkg::REG_SIZE, APB_DATA_W'(1));
    @(negedge clk_i);
    for (int i = 0; i < 9; i++) push_pixel(16'd1, 1'b0);
    drain_stream();

    // Random phases; a phase may stop mid-grid so the next size applies mid-grid.
    while (sent_items < ITEM_BUDGET) begin
      pick_config();
      @(negedge clk_i);
      fill_phase($urandom_range(80, 250));
      drain_stream();
    end

    repeat (10) @(negedge clk_i);
    if (errors == 0) begin
      $display("stencil_smoothing_3x3 test passed");
    end else begin
      $display("stencil_smoothing_3x3 test failed");
    end
    $finish;
  end

endmodule

@@ stencil_smoothing_3x3.f @@
rtl/core/stc_pkg.sv
rtl/core/stc_stream_if.sv
rtl/core/stc_cfg_regs.sv
rtl/core/stc_linebuf.sv
rtl/core/stc_window.sv
rtl/core/stc_round.sv
rtl/core/stencil_smoothing_3x3.sv
sim/testbench.sv
